/* rtl/bstp_pkg.sv */
// ----------------------------------------------------------------------------
// bstp_pkg
// Shared types and constants of the board status text parser: parser states,
// update kinds, character codes and the switch names.
// ----------------------------------------------------------------------------
package bstp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_KEY       = 4'd1,
        ST_KEY_BOOL  = 4'd2,
        ST_KEY_VALUE = 4'd3,
        ST_KEY_O     = 4'd4,
        ST_KEY_OF    = 4'd5,
        ST_KEY_NUM   = 4'd6,
        ST_KEY_NUM_M = 4'd7,
        ST_NUM       = 4'd8,
        ST_NUM_M     = 4'd9,
        ST_NUM_MX    = 4'd10,
        ST_NUM_MX_SL = 4'd11,
        ST_NUM_NUM_M = 4'd12
    } parse_state_t;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_VOLTAGE   = 3'd1,
        KIND_CURRENT   = 3'd2,
        KIND_REFERENCE = 3'd3,
        KIND_SWITCH    = 3'd4
    } update_kind_t;

    localparam int SWITCH_COUNT = 5;
    localparam int NAME_CHARS   = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_V       = 8'h76;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;

    // Switch names, first character in the lowest byte:
    // vbat, btn1, btn2, btn3, vbus.
    localparam logic [8*NAME_CHARS-1:0] SWITCH_NAME [SWITCH_COUNT] = '{
        32'h74616276,
        32'h316E7462,
        32'h326E7462,
        32'h336E7462,
        32'h73756276
    };

endpackage

/* rtl/bstp_digit_acc.sv */
// ----------------------------------------------------------------------------
// bstp_digit_acc
// Appends one decimal digit to an unsigned number, saturating at all ones.
// ----------------------------------------------------------------------------
module bstp_digit_acc #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic [NUMBER_WIDTH-1:0] acc,
    input  logic [3:0]              digit,
    output logic [NUMBER_WIDTH-1:0] result
);

    localparam int WIDE_W = NUMBER_WIDTH + 4;

    logic [WIDE_W-1:0] wide_sum;

    assign wide_sum = {acc, 3'b000} + {1'b0, acc, 2'b00} + {3'b000, acc, 1'b0}
                      - {1'b0, acc, 2'b00} + WIDE_W'(digit);
    assign result = (wide_sum[WIDE_W-1:NUMBER_WIDTH] != 4'd0) ? '1
                                                                : wide_sum[NUMBER_WIDTH-1:0];

endmodule

/* rtl/bstp_key_match.sv */
// ----------------------------------------------------------------------------
// bstp_key_match
// Compares a four character key with the five switch names and flags the hit.
// ----------------------------------------------------------------------------
module bstp_key_match (
    input  logic [8*bstp_pkg::NAME_CHARS-1:0] key_word,
    input  logic                              key_valid,
    output logic [bstp_pkg::SWITCH_COUNT-1:0] hit
);

    always_comb
    begin
        for (int i = 0; i < bstp_pkg::SWITCH_COUNT; i++)
        begin
            hit[i] = key_valid && (key_word == bstp_pkg::SWITCH_NAME[i]);
        end
    end

endmodule

/* rtl/board_status_text_parser.sv */
// ----------------------------------------------------------------------------
// board_status_text_parser
// Parses a power board status text stream one character at a time.
// ----------------------------------------------------------------------------
// The slave channel takes one character per word in s_tdata. Letters are
// folded to lower case, and the parser recognizes voltage and current pairs,
// switch settings and a reference voltage. Every accepted character gives
// exactly one result word on the master channel, carrying the update kind
// caused by that character and the complete stored status after it.
// The result word is registered and is valid after the edge that accepts its
// character. Throughput is one word per cycle while the receiver takes every
// word, set by the single result register: s_tready is high whenever that
// register is empty or is being read in the same cycle. When the receiver
// stalls, the result word is held and s_tready drops until it is taken, so no
// word is lost. Reset returns the parser to idle, clears all numbers and switch
// flags and empties the result register.
// ----------------------------------------------------------------------------
module board_status_text_parser #(
    parameter int NUMBER_WIDTH    = 16,
    parameter int KEY_STORE_CHARS = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // byte_in
    input  logic [7:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // update_kind, battery_on, button1_on, button2_on, button3_on,
    // usb_power_on, voltage_target_mv, voltage_measured_mv,
    // current_target_ma, current_measured_ma, reference_mv
    output logic [((8 + 5 * NUMBER_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int NW     = NUMBER_WIDTH;
    localparam int PACK_W = 8 + 5 * NUMBER_WIDTH;
    localparam int OUT_W  = ((PACK_W + 7) / 8) * 8;
    localparam int KIDX_W = $clog2(KEY_STORE_CHARS);
    localparam int KLEN_W = $clog2(KEY_STORE_CHARS + 2);
    localparam int SWN    = bstp_pkg::SWITCH_COUNT;

    bstp_pkg::parse_state_t state_reg, state_next;
    logic [NW-1:0]     first_reg, first_next;
    logic [NW-1:0]     second_reg, second_next;
    logic              vmode_reg, vmode_next;
    logic [7:0]        key_reg [KEY_STORE_CHARS];
    logic [KLEN_W-1:0] key_len_reg, key_len_next;
    logic              key_wr;
    logic [7:0]        key_wr_char;
    logic [KIDX_W-1:0] key_wr_idx;
    logic [SWN-1:0]    sw_reg, sw_next;
    logic [NW-1:0]     vt_reg, vt_next, vm_reg, vm_next;
    logic [NW-1:0]     ct_reg, ct_next, cm_reg, cm_next;
    logic [NW-1:0]     ref_reg, ref_next;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    bstp_pkg::update_kind_t kind;
    logic              accept;
    logic [7:0]        ch;
    logic              is_digit, is_alpha;
    logic [NW-1:0]     acc_in, acc_out;
    logic [NW-1:0]     digit_value;
    logic [SWN-1:0]    hit;
    logic              key_full;
    logic [8*bstp_pkg::NAME_CHARS-1:0] key_word;
    logic [PACK_W-1:0] pack;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign ch = (s_tdata >= bstp_pkg::CH_UPPER_A && s_tdata <= bstp_pkg::CH_UPPER_Z)
                ? (s_tdata | 8'h20) : s_tdata;
    assign is_digit    = (ch >= bstp_pkg::CH_ZERO && ch <= bstp_pkg::CH_NINE);
    assign is_alpha    = (ch >= bstp_pkg::CH_LOWER_A && ch <= bstp_pkg::CH_LOWER_Z);
    assign digit_value = NW'(ch[3:0]);
    assign acc_in      = (state_reg == bstp_pkg::ST_NUM_MX_SL) ? second_reg : first_reg;

    bstp_digit_acc #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_digit_acc (
        .acc   (acc_in),
        .digit (ch[3:0]),
        .result(acc_out)
    );

    always_comb
    begin
        for (int i = 0; i < bstp_pkg::NAME_CHARS; i++)
        begin
            key_word[8*i +: 8] = key_reg[i];
        end
    end

    assign key_full = (key_len_reg == KLEN_W'(bstp_pkg::NAME_CHARS));

    bstp_key_match u_key_match (
        .key_word (key_word),
        .key_valid(key_full),
        .hit      (hit)
    );

    always_comb
    begin
        state_next   = bstp_pkg::ST_IDLE;
        first_next   = first_reg;
        second_next  = second_reg;
        vmode_next   = vmode_reg;
        key_len_next = key_len_reg;
        key_wr       = 1'b0;
        key_wr_char  = ch;
        key_wr_idx   = key_len_reg[KIDX_W-1:0];
        sw_next      = sw_reg;
        vt_next      = vt_reg;
        vm_next      = vm_reg;
        ct_next      = ct_reg;
        cm_next      = cm_reg;
        ref_next     = ref_reg;
        kind         = bstp_pkg::KIND_NONE;
        unique case (state_reg)
            bstp_pkg::ST_NUM, bstp_pkg::ST_KEY_NUM:
            begin
                if (is_digit)
                begin
                    first_next = acc_out;
                    state_next = state_reg;
                end
                else if (ch == bstp_pkg::CH_M)
                begin
                    state_next = (state_reg == bstp_pkg::ST_NUM) ? bstp_pkg::ST_NUM_M
                                                                 : bstp_pkg::ST_KEY_NUM_M;
                end
            end
            bstp_pkg::ST_NUM_M:
            begin
                if (ch == bstp_pkg::CH_V)
                begin
                    vmode_next = 1'b1;
                    state_next = bstp_pkg::ST_NUM_MX;
                end
                else if (ch == bstp_pkg::CH_A)
                begin
                    vmode_next = 1'b0;
                    state_next = bstp_pkg::ST_NUM_MX;
                end
            end
            bstp_pkg::ST_NUM_MX:
            begin
                if (ch == bstp_pkg::CH_SLASH)
                begin
                    second_next = '0;
                    state_next  = bstp_pkg::ST_NUM_MX_SL;
                end
            end
            bstp_pkg::ST_NUM_MX_SL:
            begin
                if (is_digit)
                begin
                    second_next = acc_out;
                    state_next  = bstp_pkg::ST_NUM_MX_SL;
                end
                else if (ch == bstp_pkg::CH_M)
                begin
                    state_next = bstp_pkg::ST_NUM_NUM_M;
                end
            end
            bstp_pkg::ST_NUM_NUM_M:
            begin
                if (ch == bstp_pkg::CH_V && vmode_reg)
                begin
                    vt_next = first_reg;
                    vm_next = second_reg;
                    kind    = bstp_pkg::KIND_VOLTAGE;
                end
                else if (ch == bstp_pkg::CH_A && !vmode_reg)
                begin
                    ct_next = first_reg;
                    cm_next = second_reg;
                    kind    = bstp_pkg::KIND_CURRENT;
                end
            end
            bstp_pkg::ST_KEY:
            begin
                if (is_alpha || is_digit)
                begin
                    if (key_len_reg < KLEN_W'(KEY_STORE_CHARS))
                    begin
                        key_wr       = 1'b1;
                        key_len_next = key_len_reg + KLEN_W'(1);
                    end
                    else
                    begin
                        key_len_next = KLEN_W'(KEY_STORE_CHARS + 1);
                    end
                    state_next = bstp_pkg::ST_KEY;
                end
                else if (ch == bstp_pkg::CH_COLON)
                begin
                    state_next = bstp_pkg::ST_KEY_BOOL;
                end
                else if (ch == bstp_pkg::CH_EQUAL)
                begin
                    state_next = bstp_pkg::ST_KEY_VALUE;
                end
            end
            bstp_pkg::ST_KEY_BOOL:
            begin
                if (ch == bstp_pkg::CH_O)
                begin
                    state_next = bstp_pkg::ST_KEY_O;
                end
            end
            bstp_pkg::ST_KEY_O:
            begin
                if (ch == bstp_pkg::CH_F)
                begin
                    state_next = bstp_pkg::ST_KEY_OF;
                end
                else if (ch == bstp_pkg::CH_N && hit != '0)
                begin
                    sw_next = sw_reg | hit;
                    kind    = bstp_pkg::KIND_SWITCH;
                end
            end
            bstp_pkg::ST_KEY_OF:
            begin
                if (ch == bstp_pkg::CH_F && hit != '0)
                begin
                    sw_next = sw_reg & ~hit;
                    kind    = bstp_pkg::KIND_SWITCH;
                end
            end
            bstp_pkg::ST_KEY_VALUE:
            begin
                if (is_digit)
                begin
                    first_next = digit_value;
                    state_next = bstp_pkg::ST_KEY_NUM;
                end
            end
            bstp_pkg::ST_KEY_NUM_M:
            begin
                if (ch == bstp_pkg::CH_V)
                begin
                    ref_next = first_reg;
                    kind     = bstp_pkg::KIND_REFERENCE;
                end
            end
            default:
            begin
                if (is_digit)
                begin
                    first_next = digit_value;
                    state_next = bstp_pkg::ST_NUM;
                end
                else if (is_alpha)
                begin
                    key_wr       = 1'b1;
                    key_wr_idx   = '0;
                    key_len_next = KLEN_W'(1);
                    state_next   = bstp_pkg::ST_KEY;
                end
            end
        endcase
    end

    assign pack = {ref_next, cm_next, ct_next, vm_next, vt_next, sw_next, kind};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bstp_pkg::ST_IDLE;
            first_reg     <= '0;
            second_reg    <= '0;
            vmode_reg     <= 1'b0;
            key_len_reg   <= '0;
            sw_reg        <= '0;
            vt_reg        <= '0;
            vm_reg        <= '0;
            ct_reg        <= '0;
            cm_reg        <= '0;
            ref_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg   <= state_next;
                first_reg   <= first_next;
                second_reg  <= second_next;
                vmode_reg   <= vmode_next;
                key_len_reg <= key_len_next;
                sw_reg      <= sw_next;
                vt_reg      <= vt_next;
                vm_reg      <= vm_next;
                ct_reg      <= ct_next;
                cm_reg      <= cm_next;
                ref_reg     <= ref_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The key characters and the result word carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept && key_wr)
        begin
            key_reg[key_wr_idx] <= key_wr_char;
        end
        if (accept)
        begin
            out_data_reg <= OUT_W'(pack);
        end
    end

endmodule

/* rtl/bstp_checker.sv */
// ----------------------------------------------------------------------------
// bstp_checker
// Port-level checks of the board status text parser, bound to the top level.
// ----------------------------------------------------------------------------
module bstp_checker #(
    parameter int NUMBER_WIDTH = 16
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((8 + 5 * NUMBER_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    // A stalled result word stays valid and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The input side is open exactly when the result register can be refilled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the result register");

    // Every accepted character gives a result word in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted character gave no result word");

    // The update kind is always one of the defined codes.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == bstp_pkg::KIND_NONE
                      || m_tdata[2:0] == bstp_pkg::KIND_VOLTAGE
                      || m_tdata[2:0] == bstp_pkg::KIND_CURRENT
                      || m_tdata[2:0] == bstp_pkg::KIND_REFERENCE
                      || m_tdata[2:0] == bstp_pkg::KIND_SWITCH))
        else $error("undefined update kind");

endmodule

bind board_status_text_parser bstp_checker #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
) u_bstp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the board status text parser.
// ----------------------------------------------------------------------------
// Character words go in on the slave stream and each one is compared with a
// parser model held here that tracks the same state, numbers and switches.
// A short directed prefix is followed by random status messages, broken
// messages and noise bytes. Four phases vary the gaps on the input side and
// the stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STATUS_BITS   = 88;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 475;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int KEY_CHARS     = 4;

    typedef struct {
        bstp_pkg::update_kind_t kind;
        logic [4:0]       switches;
        logic [15:0]      volt_set;
        logic [15:0]      volt_meas;
        logic [15:0]      curr_set;
        logic [15:0]      curr_meas;
        logic [15:0]      ref_mv;
    } status_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'h00;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [STATUS_BITS-1:0] m_tdata;

    board_status_text_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [7:0]     tx_bytes [$];
    logic [7:0]     msg [$];
    status_word_t   expected_status [$];
    int unsigned    send_gap_pct = 0;
    int unsigned    recv_stall_pct = 0;
    logic           byte_taken = 1'b0;
    int unsigned    failures = 0;
    int unsigned    cycles = 0;
    int unsigned    bytes_parsed = 0;
    int unsigned    kind_seen [5] = '{0, 0, 0, 0, 0};

    // Parser model state.
    bstp_pkg::parse_state_t pst = bstp_pkg::ST_IDLE;
    logic [15:0]    num_a = '0;
    logic [15:0]    num_b = '0;
    logic           volt_mode = 1'b0;
    logic [7:0]     key_buf [KEY_CHARS];
    int unsigned    key_len = 0;
    logic [4:0]     sw_flags = '0;
    logic [15:0]    volt_pair [2] = '{16'd0, 16'd0};
    logic [15:0]    curr_pair [2] = '{16'd0, 16'd0};
    logic [15:0]    ref_value = '0;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= bstp_pkg::CH_ZERO && c <= bstp_pkg::CH_NINE;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return c >= bstp_pkg::CH_LOWER_A && c <= bstp_pkg::CH_LOWER_Z;
    endfunction

    function automatic logic [15:0] append_digit(input logic [15:0] n, input logic [7:0] c);
        int unsigned v;
        v = n * 10 + (c - bstp_pkg::CH_ZERO);
        return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic bstp_pkg::update_kind_t apply_switch(input logic on);
        if (key_len != KEY_CHARS)
            return bstp_pkg::KIND_NONE;
        for (int i = 0; i < bstp_pkg::SWITCH_COUNT; i++)
        begin
            if ({key_buf[3], key_buf[2], key_buf[1], key_buf[0]} == bstp_pkg::SWITCH_NAME[i])
            begin
                sw_flags[i] = on;
                return bstp_pkg::KIND_SWITCH;
            end
        end
        return bstp_pkg::KIND_NONE;
    endfunction

    function automatic status_word_t parse_status_byte(input logic [7:0] raw);
        logic [7:0]             c;
        bstp_pkg::update_kind_t kind;
        bstp_pkg::parse_state_t nxt;
        status_word_t           w;
        c = raw;
        if (c >= bstp_pkg::CH_UPPER_A && c <= bstp_pkg::CH_UPPER_Z)
            c = c + 8'd32;
        kind = bstp_pkg::KIND_NONE;
        nxt = bstp_pkg::ST_IDLE;
        case (pst)
            bstp_pkg::ST_NUM:
            begin
                if (is_digit(c))
                begin
                    num_a = append_digit(num_a, c);
                    nxt = bstp_pkg::ST_NUM;
                end
                else if (c == bstp_pkg::CH_M)
                    nxt = bstp_pkg::ST_NUM_M;
            end
            bstp_pkg::ST_NUM_M:
            begin
                if (c == bstp_pkg::CH_V)
                begin
                    volt_mode = 1'b1;
                    nxt = bstp_pkg::ST_NUM_MX;
                end
                else if (c == bstp_pkg::CH_A)
                begin
                    volt_mode = 1'b0;
                    nxt = bstp_pkg::ST_NUM_MX;
                end
            end
            bstp_pkg::ST_NUM_MX:
            begin
                if (c == bstp_pkg::CH_SLASH)
                begin
                    num_b = '0;
                    nxt = bstp_pkg::ST_NUM_MX_SL;
                end
            end
            bstp_pkg::ST_NUM_MX_SL:
            begin
                if (is_digit(c))
                begin
                    num_b = append_digit(num_b, c);
                    nxt = bstp_pkg::ST_NUM_MX_SL;
                end
                else if (c == bstp_pkg::CH_M)
                    nxt = bstp_pkg::ST_NUM_NUM_M;
            end
            bstp_pkg::ST_NUM_NUM_M:
            begin
                if (c == bstp_pkg::CH_V && volt_mode)
                begin
                    volt_pair[0] = num_a;
                    volt_pair[1] = num_b;
                    kind = bstp_pkg::KIND_VOLTAGE;
                end
                else if (c == bstp_pkg::CH_A && !volt_mode)
                begin
                    curr_pair[0] = num_a;
                    curr_pair[1] = num_b;
                    kind = bstp_pkg::KIND_CURRENT;
                end
            end
            bstp_pkg::ST_KEY:
            begin
                if (is_letter(c) || is_digit(c))
                begin
                    if (key_len < KEY_CHARS)
                    begin
                        key_buf[key_len] = c;
                        key_len++;
                    end
                    else
                        key_len = KEY_CHARS + 1;
                    nxt = bstp_pkg::ST_KEY;
                end
                else if (c == bstp_pkg::CH_COLON)
                    nxt = bstp_pkg::ST_KEY_BOOL;
                else if (c == bstp_pkg::CH_EQUAL)
                    nxt = bstp_pkg::ST_KEY_VALUE;
            end
            bstp_pkg::ST_KEY_BOOL:
            begin
                if (c == bstp_pkg::CH_O)
                    nxt = bstp_pkg::ST_KEY_O;
            end
            bstp_pkg::ST_KEY_O:
            begin
                if (c == bstp_pkg::CH_F)
                    nxt = bstp_pkg::ST_KEY_OF;
                else if (c == bstp_pkg::CH_N)
                    kind = apply_switch(1'b1);
            end
            bstp_pkg::ST_KEY_OF:
            begin
                if (c == bstp_pkg::CH_F)
                    kind = apply_switch(1'b0);
            end
            bstp_pkg::ST_KEY_VALUE:
            begin
                if (is_digit(c))
                begin
                    num_a = 16'(c - bstp_pkg::CH_ZERO);
                    nxt = bstp_pkg::ST_KEY_NUM;
                end
            end
            bstp_pkg::ST_KEY_NUM:
            begin
                if (is_digit(c))
                begin
                    num_a = append_digit(num_a, c);
                    nxt = bstp_pkg::ST_KEY_NUM;
                end
                else if (c == bstp_pkg::CH_M)
                    nxt = bstp_pkg::ST_KEY_NUM_M;
            end
            bstp_pkg::ST_KEY_NUM_M:
            begin
                if (c == bstp_pkg::CH_V)
                begin
                    ref_value = num_a;
                    kind = bstp_pkg::KIND_REFERENCE;
                end
            end
            default:
            begin
                if (is_digit(c))
                begin
                    num_a = 16'(c - bstp_pkg::CH_ZERO);
                    nxt = bstp_pkg::ST_NUM;
                end
                else if (is_letter(c))
                begin
                    key_buf[0] = c;
                    key_len = 1;
                    nxt = bstp_pkg::ST_KEY;
                end
            end
        endcase
        pst = nxt;
        w.kind = kind;
        w.switches = sw_flags;
        w.volt_set = volt_pair[0];
        w.volt_meas = volt_pair[1];
        w.curr_set = curr_pair[0];
        w.curr_meas = curr_pair[1];
        w.ref_mv = ref_value;
        return w;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            failures++;
            if (failures <= 10)
                $display("mismatch in %s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    // Monitor: records accepted characters and checks result words.
    always @(posedge clk)
    begin
        status_word_t exp_w;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("testbench: errors");
                $finish;
            end
            else
            begin
                if (m_tvalid && m_tready)
                begin
                    if (expected_status.size() == 0)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("result word with nothing expected: %h", m_tdata);
                    end
                    else
                    begin
                        exp_w = expected_status.pop_front();
                        check_field("update_kind", 16'(exp_w.kind), 16'(m_tdata[2:0]));
                        check_field("switches", 16'(exp_w.switches), 16'(m_tdata[7:3]));
                        check_field("voltage_target_mv", exp_w.volt_set, m_tdata[23:8]);
                        check_field("voltage_measured_mv", exp_w.volt_meas, m_tdata[39:24]);
                        check_field("current_target_ma", exp_w.curr_set, m_tdata[55:40]);
                        check_field("current_measured_ma", exp_w.curr_meas, m_tdata[71:56]);
                        check_field("reference_mv", exp_w.ref_mv, m_tdata[87:72]);
                        if (exp_w.kind <= bstp_pkg::KIND_SWITCH)
                            kind_seen[exp_w.kind]++;
                    end
                end
                if (s_tvalid && s_tready)
                begin
                    expected_status.push_back(parse_status_byte(s_tdata));
                    bytes_parsed++;
                end
            end
            byte_taken <= s_tvalid && s_tready;
        end
    end

    // Driver: presents queued characters with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || byte_taken)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= tx_bytes.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic add_char(input logic [7:0] c);
        if (c >= bstp_pkg::CH_LOWER_A && c <= bstp_pkg::CH_LOWER_Z && $urandom_range(0, 1))
            msg.push_back(c - 8'd32);
        else
            msg.push_back(c);
    endtask

    task automatic add_number();
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 9);
        if (r < 6)
            len = $urandom_range(1, 3);
        else if (r < 9)
            len = $urandom_range(4, 5);
        else
            len = $urandom_range(6, 8);
        for (int i = 0; i < len; i++)
            msg.push_back(bstp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_key();
        int unsigned r;
        int unsigned len;
        int unsigned idx;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            idx = $urandom_range(0, bstp_pkg::SWITCH_COUNT - 1);
            for (int j = 0; j < bstp_pkg::NAME_CHARS; j++)
                add_char(bstp_pkg::SWITCH_NAME[idx][8*j +: 8]);
            if (r == 6)
                add_char(bstp_pkg::CH_LOWER_A + 8'($urandom_range(0, 25)));
        end
        else
        begin
            len = $urandom_range(1, 7);
            add_char(bstp_pkg::CH_LOWER_A + 8'($urandom_range(0, 25)));
            for (int j = 1; j < len; j++)
            begin
                if ($urandom_range(0, 1))
                    add_char(bstp_pkg::CH_LOWER_A + 8'($urandom_range(0, 25)));
                else
                    msg.push_back(bstp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    task automatic build_message();
        int unsigned r;
        logic [7:0] unit_a;
        logic [7:0] unit_b;
        msg.delete();
        r = $urandom_range(0, 9);
        if (r == 9)
        begin
            repeat ($urandom_range(1, 3))
                msg.push_back(8'($urandom_range(0, 255)));
            msg.push_back(8'h0A);
        end
        else
        begin
            if (r <= 4)
            begin
                unit_a = (r <= 1) ? bstp_pkg::CH_V : bstp_pkg::CH_A;
                unit_b = unit_a;
                if (r == 4)
                    unit_b = (unit_a == bstp_pkg::CH_V) ? bstp_pkg::CH_A : bstp_pkg::CH_V;
                add_number();
                add_char(bstp_pkg::CH_M);
                add_char(unit_a);
                msg.push_back(bstp_pkg::CH_SLASH);
                add_number();
                add_char(bstp_pkg::CH_M);
                add_char(unit_b);
            end
            else if (r <= 7)
            begin
                add_key();
                msg.push_back(bstp_pkg::CH_COLON);
                add_char(bstp_pkg::CH_O);
                if ($urandom_range(0, 1))
                    add_char(bstp_pkg::CH_N);
                else
                begin
                    add_char(bstp_pkg::CH_F);
                    add_char(bstp_pkg::CH_F);
                end
            end
            else
            begin
                add_key();
                msg.push_back(bstp_pkg::CH_EQUAL);
                add_number();
                add_char(bstp_pkg::CH_M);
                add_char(bstp_pkg::CH_V);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                msg = msg[0:$urandom_range(0, msg.size() - 1)];
                msg.push_back(8'($urandom_range(0, 255)));
                msg.push_back(8'h0A);
            end
        end
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        while (tx_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_status.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (expected_status.size() != 0)
        begin
            failures += expected_status.size();
            $display("%0d result words never arrived", expected_status.size());
            expected_status.delete();
        end
    endtask

    initial
    begin
        int unsigned phase_bytes;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_text("Vbat:on");
        queue_text("1mv/2MV");
        queue_text("k=9mv");
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'h80);
        tx_bytes.push_back(8'h7F);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_gap_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                build_message();
                foreach (msg[i])
                    tx_bytes.push_back(msg[i]);
                phase_bytes += msg.size();
            end
            drain();
        end

        $display("Parsed %0d characters in four gap and stall phases.", bytes_parsed);
        $display("Updates: %0d voltage, %0d current, %0d reference, %0d switch, %0d none.",
                 kind_seen[bstp_pkg::KIND_VOLTAGE], kind_seen[bstp_pkg::KIND_CURRENT],
                 kind_seen[bstp_pkg::KIND_REFERENCE], kind_seen[bstp_pkg::KIND_SWITCH],
                 kind_seen[bstp_pkg::KIND_NONE]);
        if (failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
